/* design/mi3_pkg.sv */
// Shared types and widths for the 3x3 adjugate inverse unit.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int DATA_W  = 32;
  localparam int COF_W   = 2 * DATA_W + 1;
  localparam int DET_W   = 3 * DATA_W + 3;
  localparam int DIV_LAT = DATA_W + 1;
  localparam int TOT_LAT = DATA_W + 8;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef struct packed {
    data_t a00; data_t a01; data_t a02;
    data_t a10; data_t a11; data_t a12;
    data_t a20; data_t a21; data_t a22;
  } mi3_in_t;

  typedef struct packed {
    data_t b00; data_t b01; data_t b02;
    data_t b10; data_t b11; data_t b12;
    data_t b20; data_t b21; data_t b22;
    logic  singular;
    logic  overflow;
  } mi3_out_t;

endpackage

/* design/matrix3_inverse_unit.sv */
// Top level of the pipelined 3x3 adjugate inverse unit.
`timescale 1ns / 1ps
// Takes one Q16.16 3x3 matrix word per cycle and returns its inverse word
// through two cofactor stages, three determinant stages, a sign stage,
// one range-check stage plus one stage per quotient bit in each of nine
// divider pipelines, and the output register. busy stays low: a new word
// may enter every cycle and each result shows on out_data for one cycle
// with out_strobe high. A zero determinant gives all-zero entries with
// singular set; an out-of-range quotient saturates and sets overflow.
module matrix3_inverse_unit import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mi3_in_t  in_data,
  output logic     out_strobe,
  output mi3_out_t out_data
);

  localparam int NW = COF_W + 2 * FRAC_BITS;
  localparam logic [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MINV = {1'b1, {(DATA_W-1){1'b0}}};

  logic  c_vld, d_vld;
  cof_t  c_cof [9];
  data_t c_a0 [3];
  cof_t  d_cof [9];
  det_t  d_det;

  logic [NW-1:0]    num_r [9];
  logic [DET_W-1:0] dmag_r;
  logic             neg_r [9];
  logic             sing_r, vld_r;

  logic [DIV_LAT-1:0] vpipe_r, spipe_r;
  logic [DATA_W-1:0]  quo [9];
  logic               high [9];
  logic               qneg [9];
  logic [DATA_W-1:0]  res [9];
  logic               ovf [9];

  mi3_out_t out_nxt, out_r;
  logic     strobe_r;

  assign busy = 1'b0;

  mi3_cofactor u_cof (
    .clk(clk), .rst_n(rst_n), .vld_i(start), .item_i(in_data),
    .vld_o(c_vld), .cof_o(c_cof), .a0_o(c_a0)
  );

  mi3_det u_det (
    .clk(clk), .rst_n(rst_n), .vld_i(c_vld), .cof_i(c_cof), .a0_i(c_a0),
    .vld_o(d_vld), .cof_o(d_cof), .det_o(d_det)
  );

  always_ff @(posedge clk) begin
    dmag_r <= d_det[DET_W-1] ? DET_W'(-d_det) : DET_W'(d_det);
    sing_r <= (d_det == '0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        num_r[i*3+j] <= NW'(d_cof[j*3+i][COF_W-1] ? COF_W'(-d_cof[j*3+i])
                                                  : COF_W'(d_cof[j*3+i]))
                        << (2 * FRAC_BITS);
        neg_r[i*3+j] <= d_cof[j*3+i][COF_W-1] ^ d_det[DET_W-1];
      end
    end
  end

  for (genvar e = 0; e < 9; e++) begin : g_div
    mi3_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .num_i(num_r[e]), .dmag_i(dmag_r), .neg_i(neg_r[e]),
      .quo_o(quo[e]), .high_o(high[e]), .neg_o(qneg[e])
    );
    always_comb begin
      if (qneg[e]) begin
        ovf[e] = high[e] || (quo[e] > MINV);
        res[e] = ovf[e] ? MINV : DATA_W'(-quo[e]);
      end else begin
        ovf[e] = high[e] || quo[e][DATA_W-1];
        res[e] = ovf[e] ? MAXV : quo[e];
      end
    end
  end

  always_comb begin
    out_nxt.b00 = res[0]; out_nxt.b01 = res[1]; out_nxt.b02 = res[2];
    out_nxt.b10 = res[3]; out_nxt.b11 = res[4]; out_nxt.b12 = res[5];
    out_nxt.b20 = res[6]; out_nxt.b21 = res[7]; out_nxt.b22 = res[8];
    out_nxt.singular = 1'b0;
    out_nxt.overflow = ovf[0] | ovf[1] | ovf[2] | ovf[3] | ovf[4] |
                       ovf[5] | ovf[6] | ovf[7] | ovf[8];
    if (spipe_r[DIV_LAT-1]) begin
      out_nxt = '0;
      out_nxt.singular = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    spipe_r <= {spipe_r[DIV_LAT-2:0], sing_r};
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      vpipe_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      vld_r    <= d_vld;
      vpipe_r  <= {vpipe_r[DIV_LAT-2:0], vld_r};
      strobe_r <= vpipe_r[DIV_LAT-1];
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TOT_LAT out_strobe)
    else $error("result word missing at fixed latency");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.singular) |->
      (out_data.b00 == '0 && out_data.b11 == '0 && out_data.b22 == '0))
    else $error("singular word carries non-zero entries");

  a_sing_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_data.singular && out_data.overflow))
    else $error("singular and overflow both set");

endmodule

/* design/mi3_cofactor.sv */
// Two-stage cofactor array: products, then differences.
`timescale 1ns / 1ps
module mi3_cofactor import mi3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    vld_i,
  input  mi3_in_t item_i,
  output logic    vld_o,
  output cof_t    cof_o [9],
  output data_t   a0_o [3]
);

  data_t a [3][3];
  logic signed [2*DATA_W-1:0] p1_r [3][3];
  logic signed [2*DATA_W-1:0] p2_r [3][3];
  data_t a0p_r [3];
  data_t a0_r [3];
  cof_t  cof_r [9];
  logic  vld1_r, vld2_r;

  always_comb begin
    a[0][0] = item_i.a00; a[0][1] = item_i.a01; a[0][2] = item_i.a02;
    a[1][0] = item_i.a10; a[1][1] = item_i.a11; a[1][2] = item_i.a12;
    a[2][0] = item_i.a20; a[2][1] = item_i.a21; a[2][2] = item_i.a22;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p1_r[i][j] <= a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3];
        p2_r[i][j] <= a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
        cof_r[i*3+j] <= COF_W'(p1_r[i][j]) - COF_W'(p2_r[i][j]);
      end
      a0p_r[i] <= a[0][i];
      a0_r[i]  <= a0p_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  assign vld_o = vld2_r;
  assign cof_o = cof_r;
  assign a0_o  = a0_r;

endmodule

/* design/mi3_det.sv */
// Three-stage determinant from row 0 and its cofactors.
`timescale 1ns / 1ps
module mi3_det import mi3_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  cof_t  cof_i [9],
  input  data_t a0_i [3],
  output logic  vld_o,
  output cof_t  cof_o [9],
  output det_t  det_o
);

  logic signed [2*DATA_W:0] pl_r [3];
  logic signed [2*DATA_W:0] ph_r [3];
  det_t term_r [3];
  det_t det_r;
  cof_t c1_r [9];
  cof_t c2_r [9];
  cof_t c3_r [9];
  logic [2:0] vld_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pl_r[j]   <= a0_i[j] * $signed({1'b0, cof_i[j][DATA_W-1:0]});
      ph_r[j]   <= a0_i[j] * $signed(cof_i[j][COF_W-1:DATA_W]);
      term_r[j] <= (DET_W'(ph_r[j]) <<< DATA_W) + DET_W'(pl_r[j]);
    end
    det_r <= term_r[0] + term_r[1] + term_r[2];
    c1_r  <= cof_i;
    c2_r  <= c1_r;
    c3_r  <= c2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  assign vld_o = vld_r[2];
  assign cof_o = c3_r;
  assign det_o = det_r;

endmodule

/* design/mi3_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with range check.
`timescale 1ns / 1ps
module mi3_divider import mi3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic [COF_W+2*FRAC_BITS-1:0]  num_i,
  input  logic [DET_W-1:0]              dmag_i,
  input  logic                          neg_i,
  output logic [DATA_W-1:0]             quo_o,
  output logic                          high_o,
  output logic                          neg_o
);

  localparam int NW = COF_W + 2 * FRAC_BITS;
  localparam int RW = DET_W + 1;

  logic [RW-1:0]     r_r    [DATA_W+1];
  logic [DATA_W-1:0] lo_r   [DATA_W+1];
  logic [DATA_W-1:0] q_r    [DATA_W+1];
  logic [DET_W-1:0]  d_r    [DATA_W+1];
  logic              neg_r  [DATA_W+1];
  logic              high_r [DATA_W+1];
  logic [RW-1:0]     top;

  assign top = RW'(num_i[NW-1:DATA_W]);

  always_ff @(posedge clk) begin
    r_r[0]    <= top;
    lo_r[0]   <= num_i[DATA_W-1:0];
    q_r[0]    <= '0;
    d_r[0]    <= dmag_i;
    neg_r[0]  <= neg_i;
    high_r[0] <= (top >= RW'(dmag_i));
  end

  for (genvar k = 1; k <= DATA_W; k++) begin : g_step
    logic [RW-1:0] t;
    logic          ge;
    assign t  = {r_r[k-1][RW-2:0], lo_r[k-1][DATA_W-1]};
    assign ge = (t >= RW'(d_r[k-1]));
    always_ff @(posedge clk) begin
      r_r[k]    <= ge ? t - RW'(d_r[k-1]) : t;
      lo_r[k]   <= {lo_r[k-1][DATA_W-2:0], 1'b0};
      q_r[k]    <= {q_r[k-1][DATA_W-2:0], ge};
      d_r[k]    <= d_r[k-1];
      neg_r[k]  <= neg_r[k-1];
      high_r[k] <= high_r[k-1];
    end
  end

  assign quo_o  = q_r[DATA_W];
  assign high_o = high_r[DATA_W];
  assign neg_o  = neg_r[DATA_W];

endmodule

/* dv/tb_matrix3_inverse_unit.sv */
// Self-checking testbench for the pipelined 3x3 adjugate inverse unit.
`timescale 1ns / 1ps
module tb_matrix3_inverse_unit;
  import mi3_pkg::*;

  localparam int        STALL_LIMIT = 2000;
  localparam int        N_RANDOM    = 1400;
  localparam data_t     ONE_Q       = 32'sh0001_0000;
  localparam data_t     MAX_Q       = 32'sh7FFF_FFFF;
  localparam data_t     MIN_Q       = 32'sh8000_0000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  mi3_in_t  in_data = '0;
  logic     out_strobe;
  mi3_out_t out_data;

  mi3_in_t  matrix_q[$];
  mi3_out_t inverse_q[$];
  int       idle_pct = 0;
  int       err_cnt = 0;
  int       quiet_cycles = 0;
  logic     word_taken = 1'b0;

  matrix3_inverse_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_strobe(out_strobe), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic mi3_out_t invert_matrix(mi3_in_t m);
    logic signed [255:0] a[3][3];
    logic signed [255:0] cof[3][3];
    logic signed [255:0] det;
    logic [255:0]        dmag, nmag, quo;
    logic                nneg, dneg, ovf;
    data_t               b[3][3];
    mi3_out_t            r;
    a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
    a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
    a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                  - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
    det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    dneg = det < 0;
    dmag = dneg ? -det : det;
    ovf  = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        nneg = cof[j][i] < 0;
        nmag = nneg ? -cof[j][i] : cof[j][i];
        quo  = (nmag << (2 * 16)) / dmag;
        if (nneg != dneg) begin
          if (quo > 256'h8000_0000) begin
            b[i][j] = MIN_Q;
            ovf = 1'b1;
          end else begin
            b[i][j] = -quo[31:0];
          end
        end else begin
          if (quo > 256'h7FFF_FFFF) begin
            b[i][j] = MAX_Q;
            ovf = 1'b1;
          end else begin
            b[i][j] = quo[31:0];
          end
        end
      end
    r.b00 = b[0][0]; r.b01 = b[0][1]; r.b02 = b[0][2];
    r.b10 = b[1][0]; r.b11 = b[1][1]; r.b12 = b[1][2];
    r.b20 = b[2][0]; r.b21 = b[2][1]; r.b22 = b[2][2];
    r.overflow = ovf;
    return r;
  endfunction

  function automatic mi3_in_t make_matrix(data_t e0, data_t e1, data_t e2, data_t e3,
                                          data_t e4, data_t e5, data_t e6, data_t e7,
                                          data_t e8);
    mi3_in_t m;
    m.a00 = e0; m.a01 = e1; m.a02 = e2;
    m.a10 = e3; m.a11 = e4; m.a12 = e5;
    m.a20 = e6; m.a21 = e7; m.a22 = e8;
    return m;
  endfunction

  function automatic data_t near_unit_entry();
    return data_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  function automatic mi3_in_t random_matrix();
    mi3_in_t m;
    int      kind;
    kind = $urandom_range(0, 99);
    m = {$urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom};
    if (kind < 45) begin
      m = make_matrix(near_unit_entry(), near_unit_entry(), near_unit_entry(),
                      near_unit_entry(), near_unit_entry(), near_unit_entry(),
                      near_unit_entry(), near_unit_entry(), near_unit_entry());
    end else if (kind < 60) begin
      m.a00 = data_t'($urandom_range(0, 255)) - 128;
      m.a11 = data_t'($urandom_range(0, 255)) - 128;
      m.a22 = data_t'($urandom_range(0, 255)) - 128;
      m.a01 = $urandom_range(0, 3); m.a02 = 0; m.a10 = 0;
      m.a12 = 0; m.a20 = $urandom_range(0, 3); m.a21 = 0;
    end else if (kind < 70) begin
      m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
    end else if (kind < 75) begin
      m.a01 = 0; m.a11 = 0; m.a21 = 0;
    end
    return m;
  endfunction

  // drive at the falling edge; drop a word once it has been taken
  always @(negedge clk) begin
    if (word_taken && matrix_q.size() > 0)
      void'(matrix_q.pop_front());
    if (rst_n && matrix_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      start   <= 1'b1;
      in_data <= matrix_q[0];
    end else begin
      start   <= 1'b0;
      in_data <= {$urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
    end
  end

  always @(posedge clk) begin
    mi3_out_t exp_w;
    word_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy) begin
        inverse_q.push_back(invert_matrix(in_data));
      end
      if (out_strobe) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_data);
          err_cnt++;
        end else begin
          exp_w = inverse_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (exp_w[289-32*k -: 32] !== out_data[289-32*k -: 32]) begin
              $display("%0t: entry b%0d%0d expected %h got %h", $time, k / 3, k % 3,
                       exp_w[289-32*k -: 32], out_data[289-32*k -: 32]);
              err_cnt++;
            end
          if (exp_w.singular !== out_data.singular) begin
            $display("%0t: singular expected %b got %b", $time,
                     exp_w.singular, out_data.singular);
            err_cnt++;
          end
          if (exp_w.overflow !== out_data.overflow) begin
            $display("%0t: overflow expected %b got %b", $time,
                     exp_w.overflow, out_data.overflow);
            err_cnt++;
          end
        end
      end
      quiet_cycles <= ((start && !busy) || out_strobe) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    mi3_in_t m;
    matrix_q.push_back(make_matrix(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
    matrix_q.push_back(make_matrix(-ONE_Q, 0, 0, 0, 2*ONE_Q, 0, 0, 0, -4*ONE_Q));
    matrix_q.push_back('0);
    matrix_q.push_back(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
    matrix_q.push_back(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, -1));
    matrix_q.push_back(make_matrix(MAX_Q, 0, 0, 0, MAX_Q, 0, 0, 0, MAX_Q));
    matrix_q.push_back(make_matrix(MIN_Q, 0, 0, 0, MIN_Q, 0, 0, 0, MIN_Q));
    matrix_q.push_back(make_matrix(MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MAX_Q,
                                   MIN_Q, MIN_Q, MAX_Q));
    matrix_q.push_back(make_matrix(MIN_Q, MAX_Q, MIN_Q, MIN_Q, MIN_Q, MAX_Q,
                                   MAX_Q, MIN_Q, MIN_Q));
    matrix_q.push_back({9{MAX_Q}});
    matrix_q.push_back({9{MIN_Q}});
    matrix_q.push_back({9{32'shFFFF_FFFF}});
    matrix_q.push_back(make_matrix(0, ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, 0, 0));
    matrix_q.push_back(make_matrix(2*ONE_Q, ONE_Q, 0, ONE_Q, 2*ONE_Q, ONE_Q,
                                   0, ONE_Q, 2*ONE_Q));
    matrix_q.push_back(make_matrix(3*ONE_Q, 0, 0, 0, 3*ONE_Q, 0, 0, 0, 3*ONE_Q));
    matrix_q.push_back(make_matrix(ONE_Q, 2*ONE_Q, 3*ONE_Q, 4*ONE_Q, 5*ONE_Q,
                                   6*ONE_Q, 7*ONE_Q, 8*ONE_Q, 9*ONE_Q));
    matrix_q.push_back(make_matrix(1, 1, 0, 0, 1, 1, 1, 0, 1));
    matrix_q.push_back(make_matrix(MIN_Q, 0, 0, 0, 1, 0, 0, 0, -1));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 350 == 0) begin
        wait (matrix_q.size() == 0);
        case (n / 350)
          0: idle_pct = 0;
          1: idle_pct = 70;
          2: idle_pct = 22;
          default: idle_pct = 0;
        endcase
      end
      m = random_matrix();
      matrix_q.push_back(m);
      if (matrix_q.size() > 64) wait (matrix_q.size() < 16);
    end
    wait (matrix_q.size() == 0 && !word_taken);
    wait (inverse_q.size() == 0);
    repeat (TOT_LAT + 10) @(posedge clk);
    if (err_cnt == 0 && inverse_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
